FILE: hw/rtl/mwfd_pkg.sv
`timescale 1ns / 1ps

package mwfd_pkg;

   // Window sizes.
   localparam int RAW_WINDOW     = 5;
   localparam int MEDIAN_HISTORY = 30;

   // Field widths.
   localparam int TEMP_W     = 7;
   localparam int HCOUNT_W   = 5;
   localparam int CAUSE_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   // Derived sizes.
   localparam int RAW_CELLS   = RAW_WINDOW - 1;
   localparam int RANK_W      = $clog2(RAW_WINDOW);
   localparam int MEDIAN_RANK = (RAW_WINDOW - 1) / 2;
   localparam int TALLY_W     = $clog2(MEDIAN_HISTORY + 1);
   localparam int ROT_W       = (MEDIAN_HISTORY > 2) ? $clog2(MEDIAN_HISTORY) : 1;
   localparam int TALLY_CMP_W = (TALLY_W > HCOUNT_W) ? TALLY_W : HCOUNT_W;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_THRESHOLD    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_COUNT_NEEDED = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RISE_THRESHOLD    = 2'd2;

   // Register reset values.
   localparam logic [TEMP_W-1:0]   HIGH_THRESHOLD_RESET    = 7'd58;
   localparam logic [HCOUNT_W-1:0] HIGH_COUNT_NEEDED_RESET = 5'd27;
   localparam logic [TEMP_W-1:0]   RISE_THRESHOLD_RESET    = 7'd8;

   // Cause codes.
   localparam logic [CAUSE_W-1:0] CAUSE_NONE = 2'd0;
   localparam int CAUSE_HIGH_BIT = 0;
   localparam int CAUSE_RISE_BIT = 1;

   typedef logic [TEMP_W-1:0] temp_type;

   typedef struct packed {
      logic     valid;
      temp_type value;
   } mwfd_cell_type;

   typedef struct packed {
      logic     advance;
      temp_type high_threshold;
   } mwfd_hist_ctl_type;

   typedef enum logic {
      ST_RUN,
      ST_RECOUNT
   } mwfd_state_type;

endpackage

FILE: hw/rtl/mwfd_if.sv
`timescale 1ns / 1ps

interface mwfd_req_if;
   import mwfd_pkg::*;
   logic     valid;
   logic     ready;
   temp_type temperature;
   modport source (output valid, output temperature, input ready);
   modport sink (input valid, input temperature, output ready);
endinterface

interface mwfd_rsp_if;
   import mwfd_pkg::*;
   logic               valid;
   logic               ready;
   logic               alarm;
   logic [CAUSE_W-1:0] cause;
   logic               median_valid;
   temp_type           median_value;
   modport source (output valid, output alarm, output cause, output median_valid,
                   output median_value, input ready);
   modport sink (input valid, input alarm, input cause, input median_valid,
                 input median_value, output ready);
endinterface

interface mwfd_csr_if;
   import mwfd_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0]  write_data;
   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

FILE: hw/rtl/median_window_fire_detector.sv
`timescale 1ns / 1ps

// Median-window fire detector.
// The req channel carries one temperature reading per transaction. The rsp
// channel returns exactly one transaction per reading: the latched alarm, the
// cause found by this reading, and the new median when one was formed. The
// csr channel writes the high threshold, the high count needed and the rise
// threshold by register index; writes to other indexes are dropped.
// Rsp valid follows req acceptance in the next cycle, and a new reading is
// accepted every cycle barring a csr write or recount: the response sits in an
// output register, and req stays ready while that register is being taken.
// The five-sample median comes from a rank-select network in the same cycle,
// and the thirty medians live in a chain of cells that shifts once per median
// while a running tally of high medians is kept up to date.
// A write to the high threshold starts a recount: the history chain rotates
// once around, recounting high medians against the new threshold.
// Neither req nor csr is accepted during the recount, and req waits while a
// csr write is offered.
// Reset clears the sample and median histories, the tally and the alarm, and
// loads the register defaults. When rsp stalls, req is held off once the
// output register is full; no reading is lost or reordered.
module median_window_fire_detector (
   input logic       clock,
   input logic       reset,
   mwfd_req_if.sink   req_chan,
   mwfd_rsp_if.source rsp_chan,
   mwfd_csr_if.sink   csr_chan
);
   import mwfd_pkg::*;

   // Configuration registers.
   temp_type              high_threshold_ff, high_threshold_in;
   logic [HCOUNT_W-1:0]   high_count_needed_ff, high_count_needed_in;
   temp_type              rise_threshold_ff, rise_threshold_in;

   // Control state.
   mwfd_state_type        state_ff, state_in;
   logic [ROT_W-1:0]      rot_count_ff, rot_count_in;
   logic [TALLY_W-1:0]    tally_ff, tally_in;
   logic                  alarm_ff, alarm_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_alarm_ff, rsp_alarm_in;
   logic [CAUSE_W-1:0]    rsp_cause_ff, rsp_cause_in;
   logic                  rsp_mvalid_ff, rsp_mvalid_in;
   temp_type              rsp_mvalue_ff, rsp_mvalue_in;

   // Handshakes and decoded control.
   logic                  req_fire;
   logic                  csr_fire;
   logic                  step;
   logic                  rotate;
   logic                  accepting;
   logic                  csr_open;
   logic                  hist_shift;
   logic                  thr_write;

   // Chains.
   mwfd_cell_type         raw_d [RAW_CELLS];
   mwfd_cell_type         raw_q [RAW_CELLS];
   mwfd_cell_type         hist_d [MEDIAN_HISTORY];
   mwfd_cell_type         hist_q [MEDIAN_HISTORY];
   logic                  hist_high [MEDIAN_HISTORY];
   mwfd_hist_ctl_type     hist_ctl;
   temp_type              rank_window [RAW_WINDOW];
   temp_type              median;

   // Per-reading findings.
   logic                  raw_full;
   logic                  hist_full;
   temp_type              oldest;
   logic                  hi_new;
   logic                  hi_drop;
   logic [TALLY_W-1:0]    tally_upd;
   logic [TEMP_W:0]       rise_diff;
   logic [CAUSE_W-1:0]    cause;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign csr_fire  = csr_chan.valid && csr_chan.ready;
   assign step      = req_fire && !alarm_ff;
   assign thr_write = csr_fire && (csr_chan.reg_index == CSR_HIGH_THRESHOLD);

   // ---------------------------------------------------------------------
   // Sequencer: normal operation, or rotating recount after a new threshold.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (thr_write) begin
               state_in = ST_RECOUNT;
            end
         end
         ST_RECOUNT: begin
            if (rot_count_ff == ROT_W'(MEDIAN_HISTORY - 1)) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      rotate    = 1'b0;
      accepting = 1'b0;
      csr_open  = 1'b0;
      case (state_ff)
         ST_RUN: begin
            accepting = 1'b1;
            csr_open  = 1'b1;
         end
         ST_RECOUNT: begin
            rotate = 1'b1;
         end
         default: begin
            rotate = 1'b0;
         end
      endcase
   end

   // A register write takes priority, so a reading never shares its cycle.
   assign req_chan.ready = accepting && !csr_chan.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign csr_chan.ready = csr_open;

   always_comb begin
      rot_count_in = rot_count_ff;
      if (rotate) begin
         rot_count_in = rot_count_ff + ROT_W'(1);
      end else if (thr_write) begin
         rot_count_in = '0;
      end
   end

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   always_comb begin
      high_threshold_in    = high_threshold_ff;
      high_count_needed_in = high_count_needed_ff;
      rise_threshold_in    = rise_threshold_ff;
      if (csr_fire) begin
         case (csr_chan.reg_index)
            CSR_HIGH_THRESHOLD:    high_threshold_in    = csr_chan.write_data[TEMP_W-1:0];
            CSR_HIGH_COUNT_NEEDED: high_count_needed_in = csr_chan.write_data[HCOUNT_W-1:0];
            CSR_RISE_THRESHOLD:    rise_threshold_in    = csr_chan.write_data[TEMP_W-1:0];
            default: begin
               high_threshold_in = high_threshold_ff;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Raw sample chain. The oldest raw sample drops out on every reading taken
   // before the alarm latches, so only the four that survive the shift are stored.
   // ---------------------------------------------------------------------
   genvar gi;
   generate
      for (gi = 0; gi < RAW_CELLS; gi++) begin : g_raw
         if (gi == 0) begin : g_head
            assign raw_d[gi] = '{valid: 1'b1, value: req_chan.temperature};
         end else begin : g_body
            assign raw_d[gi] = raw_q[gi-1];
         end
         mwfd_raw_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (step),
            .d_in    (raw_d[gi]),
            .q_out   (raw_q[gi])
         );
      end
   endgenerate

   // The window after this reading is the reading plus the stored samples.
   always_comb begin
      rank_window[0] = req_chan.temperature;
      for (int i = 1; i < RAW_WINDOW; i++) begin
         rank_window[i] = raw_q[i-1].value;
      end
   end

   mwfd_median u_median (
      .window (rank_window),
      .median (median)
   );

   // ---------------------------------------------------------------------
   // Median history chain. It shifts in a new median, or rotates with its
   // tail feeding its head during a recount.
   // ---------------------------------------------------------------------
   assign hist_ctl = '{advance: hist_shift || rotate, high_threshold: high_threshold_ff};

   generate
      for (gi = 0; gi < MEDIAN_HISTORY; gi++) begin : g_hist
         if (gi == 0) begin : g_head
            assign hist_d[gi] = rotate ? hist_q[MEDIAN_HISTORY-1]
                                       : mwfd_cell_type'{valid: 1'b1, value: median};
         end else begin : g_body
            assign hist_d[gi] = hist_q[gi-1];
         end
         mwfd_hist_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctl   (hist_ctl),
            .d_in  (hist_d[gi]),
            .q_out (hist_q[gi]),
            .high  (hist_high[gi])
         );
      end
   endgenerate

   // ---------------------------------------------------------------------
   // Findings for the current reading. The history is full after the shift
   // when the next-to-last cell already holds a median, and that median then
   // becomes the oldest one.
   // ---------------------------------------------------------------------
   assign raw_full  = raw_q[RAW_CELLS-1].valid;
   assign hist_full = hist_q[MEDIAN_HISTORY-2].valid;
   assign oldest    = hist_q[MEDIAN_HISTORY-2].value;
   assign hi_new    = median >= high_threshold_ff;
   assign hi_drop   = hist_high[MEDIAN_HISTORY-1];
   assign tally_upd = tally_ff + TALLY_W'(hi_new) - TALLY_W'(hi_drop);
   assign rise_diff = {1'b0, req_chan.temperature} - {1'b0, oldest};

   always_comb begin
      cause = CAUSE_NONE;
      if (hist_full) begin
         cause[CAUSE_HIGH_BIT] = TALLY_CMP_W'(tally_upd) >= TALLY_CMP_W'(high_count_needed_ff);
         cause[CAUSE_RISE_BIT] = (oldest != '0) && !rise_diff[TEMP_W] &&
                                 (rise_diff[TEMP_W-1:0] >= rise_threshold_ff);
      end
   end

   // ---------------------------------------------------------------------
   // State update and response formation.
   // ---------------------------------------------------------------------
   always_comb begin
      tally_in      = tally_ff;
      alarm_in      = alarm_ff;
      hist_shift    = 1'b0;
      rsp_alarm_in  = rsp_alarm_ff;
      rsp_cause_in  = rsp_cause_ff;
      rsp_mvalid_in = rsp_mvalid_ff;
      rsp_mvalue_in = rsp_mvalue_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rotate) begin
         tally_in = tally_ff + TALLY_W'(hist_high[MEDIAN_HISTORY-1]);
      end else if (thr_write) begin
         tally_in = '0;
      end else if (step && raw_full) begin
         hist_shift = 1'b1;
         tally_in   = tally_upd;
         if (cause != CAUSE_NONE) begin
            alarm_in = 1'b1;
         end
      end

      if (req_fire) begin
         rsp_valid_in = 1'b1;
         if (alarm_ff) begin
            // Latched: the reading is dropped and only the alarm is reported.
            rsp_alarm_in  = 1'b1;
            rsp_cause_in  = CAUSE_NONE;
            rsp_mvalid_in = 1'b0;
            rsp_mvalue_in = '0;
         end else begin
            rsp_alarm_in  = alarm_in;
            rsp_cause_in  = raw_full ? cause : CAUSE_NONE;
            rsp_mvalid_in = raw_full;
            rsp_mvalue_in = raw_full ? median : '0;
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_RUN;
         rot_count_ff         <= '0;
         tally_ff             <= '0;
         alarm_ff             <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         high_threshold_ff    <= HIGH_THRESHOLD_RESET;
         high_count_needed_ff <= HIGH_COUNT_NEEDED_RESET;
         rise_threshold_ff    <= RISE_THRESHOLD_RESET;
      end else begin
         state_ff             <= state_in;
         rot_count_ff         <= rot_count_in;
         tally_ff             <= tally_in;
         alarm_ff             <= alarm_in;
         rsp_valid_ff         <= rsp_valid_in;
         high_threshold_ff    <= high_threshold_in;
         high_count_needed_ff <= high_count_needed_in;
         rise_threshold_ff    <= rise_threshold_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_alarm_ff  <= rsp_alarm_in;
      rsp_cause_ff  <= rsp_cause_in;
      rsp_mvalid_ff <= rsp_mvalid_in;
      rsp_mvalue_ff <= rsp_mvalue_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.alarm        = rsp_alarm_ff;
   assign rsp_chan.cause        = rsp_cause_ff;
   assign rsp_chan.median_valid = rsp_mvalid_ff;
   assign rsp_chan.median_value = rsp_mvalue_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   // Once latched, the alarm stays latched until reset.
   assert property (@(posedge clock) disable iff (reset) alarm_ff |=> alarm_ff)
      else $error("alarm latch released without reset");

   // No reading may enter while the history is being recounted.
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_RECOUNT) |-> !req_chan.ready)
      else $error("reading accepted during recount");

   // A finding in a response always comes with the alarm raised.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_chan.valid && (rsp_chan.cause != CAUSE_NONE)) |-> rsp_chan.alarm)
      else $error("cause reported without alarm");

   // The running tally can never count more medians than the history holds.
   assert property (@(posedge clock) disable iff (reset)
                    tally_ff <= TALLY_W'(MEDIAN_HISTORY))
      else $error("high median tally out of range");

endmodule

FILE: hw/rtl/mwfd_raw_cell.sv
`timescale 1ns / 1ps

module mwfd_raw_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  mwfd_pkg::mwfd_cell_type d_in,
   output mwfd_pkg::mwfd_cell_type q_out
);
   import mwfd_pkg::*;

   logic     valid_ff;
   temp_type value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= d_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff <= d_in.value;
      end
   end

   assign q_out = '{valid: valid_ff, value: value_ff};

endmodule

FILE: hw/rtl/mwfd_hist_cell.sv
`timescale 1ns / 1ps

module mwfd_hist_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  mwfd_pkg::mwfd_hist_ctl_type ctl,
   input  mwfd_pkg::mwfd_cell_type     d_in,
   output mwfd_pkg::mwfd_cell_type     q_out,
   output logic                       high
);
   import mwfd_pkg::*;

   logic     valid_ff;
   temp_type value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= d_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         value_ff <= d_in.value;
      end
   end

   // A held median counts as high only once it has been written.
   assign high  = valid_ff && (value_ff >= ctl.high_threshold);
   assign q_out = '{valid: valid_ff, value: value_ff};

endmodule

FILE: hw/rtl/mwfd_median.sv
`timescale 1ns / 1ps

module mwfd_median (
   input  mwfd_pkg::temp_type window [mwfd_pkg::RAW_WINDOW],
   output mwfd_pkg::temp_type median
);
   import mwfd_pkg::*;

   logic [RANK_W-1:0] rank [RAW_WINDOW];

   // Each sample's rank counts the samples below it; equal samples are
   // ordered by position, so the ranks are all distinct.
   always_comb begin
      for (int j = 0; j < RAW_WINDOW; j++) begin
         rank[j] = '0;
         for (int k = 0; k < RAW_WINDOW; k++) begin
            if ((k != j) &&
                ((window[k] < window[j]) || ((window[k] == window[j]) && (k < j)))) begin
               rank[j] = rank[j] + RANK_W'(1);
            end
         end
      end
   end

   always_comb begin
      median = '0;
      for (int j = 0; j < RAW_WINDOW; j++) begin
         if (rank[j] == RANK_W'(MEDIAN_RANK)) begin
            median = window[j];
         end
      end
   end

endmodule
